/* design/kabf_pkg.sv */
`timescale 1ns / 1ps
package kabf_pkg;

    localparam int AXES_DEFAULT = 3;
    localparam int NOISE_W      = 31;
    localparam int VAL_W        = 32;
    localparam int DT_W         = 24;
    localparam int MUL_A_W      = 36;
    localparam int MUL_B_W      = 33;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;

    localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 31'd1073742;
    localparam logic [NOISE_W-1:0] BIAS_NOISE_RST    = 31'd3221225;
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 31'd32212255;

    typedef enum logic [1:0] {
        REG_ANGLE_NOISE   = 2'd0,
        REG_BIAS_NOISE    = 2'd1,
        REG_MEASURE_NOISE = 2'd2
    } cfg_reg_t;

    localparam logic CMD_UPDATE    = 1'b0;
    localparam logic CMD_SET_ANGLE = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_SET, ST_RATE, ST_TERM, ST_ANG, ST_PRED, ST_P11,
        ST_DIVI, ST_DIV, ST_GAIN, ST_KY0, ST_KY1, ST_KP00, ST_KP01, ST_KP10,
        ST_KP11, ST_WB, ST_DONE
    } state_t;

    // clip to the signed 32-bit range
    function automatic logic signed [31:0] sat_val(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic sat_ovf(input logic signed [63:0] x);
        return (x > 64'sd2147483647) || (x < -64'sd2147483648);
    endfunction

    // round half up, then arithmetic shift
    function automatic logic signed [63:0] rnd24(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] u;
        logic signed [PROD_W-1:0] r;
        u = p + (PROD_W'(1) <<< 23);
        r = u >>> 24;
        return 64'(r);
    endfunction

    function automatic logic signed [63:0] rnd30(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] u;
        logic signed [PROD_W-1:0] r;
        u = p + (PROD_W'(1) <<< 29);
        r = u >>> 30;
        return 64'(r);
    endfunction

    function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
        return 64'(v);
    endfunction

endpackage

/* design/kalman_angle_bias_filter.sv */
`timescale 1ns / 1ps
// Two-state angle / gyro-bias Kalman filter for up to AXES axes, with noise settings shared by
// all axes. An update item (tuser cmd 0) goes from one accepted transaction to the next
// through a load state, the prediction states RATE, TERM, ANG, PRED and P11, a 32-step radix-2
// divider with a setup state and a gain state that forms both gains side by side, the
// correction and write-back states KY0 to KP11 and WB, and the output state. Ten products go
// through one shared 36x33 multiplier with a registered product. When the innovation variance
// is not positive the divider is skipped. A set-angle item goes through LOAD, SET and DONE, and
// an item for an axis out of range goes from LOAD straight to DONE. s_tready is high only while
// no item is being worked on; a finished result sits in the output register so the next item
// can be taken while it waits, and the block holds in its output state for as long as that
// register is full and m_tready is low. Write the noise registers only while the block is idle.
module kalman_angle_bias_filter
    import kabf_pkg::*;
#(
    parameter int AXES = AXES_DEFAULT
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // measured_angle[31:0], gyro_rate[63:32], time_step[87:64]
    input  logic [2:0]   s_tuser,   // cmd[0], axis[2:1]
    output logic         m_tvalid,
    input  logic         m_tready,
    // angle_estimate[31:0], unbiased_rate[63:32], bias_estimate[95:64]
    output logic [95:0]  m_tdata,
    output logic [2:0]   m_tuser,   // out_axis[1:0], saturated[2]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data
);

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    state_t state_reg, state_next;

    logic [NOISE_W-1:0] angle_noise_reg, bias_noise_reg, measure_noise_reg;

    logic signed [31:0] angle_mem [AXES];
    logic signed [31:0] bias_mem  [AXES];
    logic signed [31:0] rate_mem  [AXES];
    logic signed [31:0] p00_mem   [AXES];
    logic signed [31:0] p01_mem   [AXES];
    logic signed [31:0] p10_mem   [AXES];
    logic signed [31:0] p11_mem   [AXES];

    logic               cmd_reg;
    logic [1:0]         axis_reg;
    logic               valid_axis_reg;
    logic signed [31:0] meas_reg, gyro_reg;
    logic [DT_W-1:0]    dt_reg;

    logic signed [31:0] ang_reg, bias_reg, rate_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [32:0] t_reg;
    logic signed [33:0] s_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] k0_reg, k1_reg;
    logic               flag_reg;

    logic [31:0]        rem0_reg, rem1_reg, low0_reg, low1_reg, q0_reg, q1_reg, d_reg;
    logic               ov0_reg, ov1_reg, neg0_reg, neg1_reg;
    logic [4:0]         cnt_reg;

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_A_W-1:0] e_term;

    logic               m_tvalid_reg;
    logic [95:0]        m_tdata_reg;
    logic [2:0]         m_tuser_reg;

    logic               in_fire, out_free;
    logic [AW-1:0]      ax;
    logic signed [MUL_B_W-1:0] dt_b;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign ax        = AW'(axis_reg);
    assign dt_b      = MUL_B_W'({1'b0, dt_reg});
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign e_term = MUL_A_W'(t_reg) - MUL_A_W'(p01_reg) - MUL_A_W'(p10_reg)
                  + MUL_A_W'({1'b0, angle_noise_reg});

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RATE: begin mul_a = MUL_A_W'(p11_reg); mul_b = dt_b; end
            ST_TERM: begin mul_a = MUL_A_W'(rate_reg); mul_b = dt_b; end
            ST_ANG:  begin mul_a = e_term; mul_b = dt_b; end
            ST_PRED: begin mul_a = MUL_A_W'({1'b0, bias_noise_reg}); mul_b = dt_b; end
            ST_KY0:  begin mul_a = MUL_A_W'(k0_reg); mul_b = MUL_B_W'(y_reg); end
            ST_KY1:  begin mul_a = MUL_A_W'(k1_reg); mul_b = MUL_B_W'(y_reg); end
            ST_KP00: begin mul_a = MUL_A_W'(p00_reg); mul_b = MUL_B_W'(k0_reg); end
            ST_KP01: begin mul_a = MUL_A_W'(p01_reg); mul_b = MUL_B_W'(k0_reg); end
            ST_KP10: begin mul_a = MUL_A_W'(p00_reg); mul_b = MUL_B_W'(k1_reg); end
            ST_KP11: begin mul_a = MUL_A_W'(p01_reg); mul_b = MUL_B_W'(k1_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (!valid_axis_reg)
                    state_next = ST_DONE;
                else if (cmd_reg == CMD_SET_ANGLE)
                    state_next = ST_SET;
                else
                    state_next = ST_RATE;
            end
            ST_SET:  state_next = ST_DONE;
            ST_RATE: state_next = ST_TERM;
            ST_TERM: state_next = ST_ANG;
            ST_ANG:  state_next = ST_PRED;
            ST_PRED: state_next = ST_P11;
            ST_P11:  state_next = ST_DIVI;
            ST_DIVI: state_next = (s_reg <= 34'sd0) ? ST_KY0 : ST_DIV;
            ST_DIV:  if (cnt_reg == 5'd31) state_next = ST_GAIN;
            ST_GAIN: state_next = ST_KY0;
            ST_KY0:  state_next = ST_KY1;
            ST_KY1:  state_next = ST_KP00;
            ST_KP00: state_next = ST_KP01;
            ST_KP01: state_next = ST_KP10;
            ST_KP10: state_next = ST_KP11;
            ST_KP11: state_next = ST_WB;
            ST_WB:   state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // noise settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_noise_reg   <= ANGLE_NOISE_RST;
            bias_noise_reg    <= BIAS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ANGLE_NOISE:   angle_noise_reg   <= cfg_data;
                REG_BIAS_NOISE:    bias_noise_reg    <= cfg_data;
                REG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-axis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                angle_mem[i] <= '0;
                bias_mem[i]  <= '0;
                rate_mem[i]  <= '0;
                p00_mem[i]   <= '0;
                p01_mem[i]   <= '0;
                p10_mem[i]   <= '0;
                p11_mem[i]   <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_SET:  angle_mem[ax] <= meas_reg;
                ST_KP01: p00_mem[ax] <= sat_val(sx32(p00_reg) - rnd30(prod_reg));
                ST_KP10: p01_mem[ax] <= sat_val(sx32(p01_reg) - rnd30(prod_reg));
                ST_KP11: p10_mem[ax] <= sat_val(sx32(p10_reg) - rnd30(prod_reg));
                ST_WB:
                begin
                    p11_mem[ax]   <= sat_val(sx32(p11_reg) - rnd30(prod_reg));
                    angle_mem[ax] <= ang_reg;
                    bias_mem[ax]  <= bias_reg;
                    rate_mem[ax]  <= rate_reg;
                end
                default: ;
            endcase
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        logic signed [63:0] x;
        logic [63:0]        n0, n1;
        logic [32:0]        tr0, tr1;
        logic               big0, big1;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_reg        <= s_tuser[0];
                    axis_reg       <= s_tuser[2:1];
                    valid_axis_reg <= ({2'b0, s_tuser[2:1]} < 4'(AXES));
                    meas_reg       <= s_tdata[31:0];
                    gyro_reg       <= s_tdata[63:32];
                    dt_reg         <= s_tdata[87:64];
                    flag_reg       <= 1'b0;
                end
            end
            ST_LOAD:
            begin
                if (valid_axis_reg)
                begin
                    ang_reg  <= angle_mem[ax];
                    bias_reg <= bias_mem[ax];
                    rate_reg <= rate_mem[ax];
                    p00_reg  <= p00_mem[ax];
                    p01_reg  <= p01_mem[ax];
                    p10_reg  <= p10_mem[ax];
                    p11_reg  <= p11_mem[ax];
                end
                else
                begin
                    ang_reg  <= '0;
                    bias_reg <= '0;
                    rate_reg <= '0;
                end
            end
            ST_SET: ang_reg <= meas_reg;
            ST_RATE:
            begin
                x = sx32(gyro_reg) - sx32(bias_reg);
                rate_reg <= sat_val(x);
                flag_reg <= flag_reg | sat_ovf(x);
            end
            ST_TERM: t_reg <= 33'(rnd24(prod_reg));
            ST_ANG:
            begin
                x = sx32(ang_reg) + rnd24(prod_reg);
                ang_reg  <= sat_val(x);
                flag_reg <= flag_reg | sat_ovf(x);
            end
            ST_PRED:
            begin
                p00_reg  <= sat_val(sx32(p00_reg) + rnd24(prod_reg));
                p01_reg  <= sat_val(sx32(p01_reg) - 64'(t_reg));
                p10_reg  <= sat_val(sx32(p10_reg) - 64'(t_reg));
                flag_reg <= flag_reg | sat_ovf(sx32(p00_reg) + rnd24(prod_reg))
                          | sat_ovf(sx32(p01_reg) - 64'(t_reg))
                          | sat_ovf(sx32(p10_reg) - 64'(t_reg));
            end
            ST_P11:
            begin
                x = sx32(p11_reg) + rnd24(prod_reg);
                p11_reg  <= sat_val(x);
                s_reg    <= 34'(p00_reg) + 34'({1'b0, measure_noise_reg});
                y_reg    <= sat_val(sx32(meas_reg) - sx32(ang_reg));
                flag_reg <= flag_reg | sat_ovf(x) | sat_ovf(sx32(meas_reg) - sx32(ang_reg));
            end
            ST_DIVI:
            begin
                if (s_reg <= 34'sd0)
                begin
                    // innovation variance not positive: no correction gain
                    flag_reg <= 1'b1;
                    k0_reg   <= '0;
                    k1_reg   <= '0;
                end
                else
                begin
                    n0 = {2'b0, (p00_reg[31] ? 32'(-p00_reg) : 32'(p00_reg)), 30'b0}
                       + {33'b0, s_reg[31:1]};
                    n1 = {2'b0, (p10_reg[31] ? 32'(-p10_reg) : 32'(p10_reg)), 30'b0}
                       + {33'b0, s_reg[31:1]};
                    d_reg    <= s_reg[31:0];
                    rem0_reg <= n0[63:32];
                    rem1_reg <= n1[63:32];
                    low0_reg <= n0[31:0];
                    low1_reg <= n1[31:0];
                    ov0_reg  <= (n0[63:32] >= s_reg[31:0]);
                    ov1_reg  <= (n1[63:32] >= s_reg[31:0]);
                    neg0_reg <= p00_reg[31];
                    neg1_reg <= p10_reg[31];
                    cnt_reg  <= '0;
                end
            end
            ST_DIV:
            begin
                tr0 = {rem0_reg, low0_reg[31]};
                tr1 = {rem1_reg, low1_reg[31]};
                if (tr0 >= {1'b0, d_reg})
                begin
                    rem0_reg <= 32'(tr0 - {1'b0, d_reg});
                    q0_reg   <= {q0_reg[30:0], 1'b1};
                end
                else
                begin
                    rem0_reg <= tr0[31:0];
                    q0_reg   <= {q0_reg[30:0], 1'b0};
                end
                if (tr1 >= {1'b0, d_reg})
                begin
                    rem1_reg <= 32'(tr1 - {1'b0, d_reg});
                    q1_reg   <= {q1_reg[30:0], 1'b1};
                end
                else
                begin
                    rem1_reg <= tr1[31:0];
                    q1_reg   <= {q1_reg[30:0], 1'b0};
                end
                low0_reg <= {low0_reg[30:0], 1'b0};
                low1_reg <= {low1_reg[30:0], 1'b0};
                cnt_reg  <= cnt_reg + 5'd1;
            end
            ST_GAIN:
            begin
                big0 = ov0_reg || q0_reg[31];
                big1 = ov1_reg || q1_reg[31];
                if (neg0_reg)
                    k0_reg <= big0 ? 32'sh80000000 : -$signed(q0_reg);
                else
                    k0_reg <= big0 ? 32'sh7FFFFFFF : $signed(q0_reg);
                if (neg1_reg)
                    k1_reg <= big1 ? 32'sh80000000 : -$signed(q1_reg);
                else
                    k1_reg <= big1 ? 32'sh7FFFFFFF : $signed(q1_reg);
                flag_reg <= flag_reg | (big0 && !neg0_reg) | (big1 && !neg1_reg);
            end
            ST_KY1:
            begin
                x = sx32(ang_reg) + rnd30(prod_reg);
                ang_reg  <= sat_val(x);
                flag_reg <= flag_reg | sat_ovf(x);
            end
            ST_KP00:
            begin
                x = sx32(bias_reg) + rnd30(prod_reg);
                bias_reg <= sat_val(x);
                flag_reg <= flag_reg | sat_ovf(x);
            end
            ST_KP01: flag_reg <= flag_reg | sat_ovf(sx32(p00_reg) - rnd30(prod_reg));
            ST_KP10: flag_reg <= flag_reg | sat_ovf(sx32(p01_reg) - rnd30(prod_reg));
            ST_KP11: flag_reg <= flag_reg | sat_ovf(sx32(p10_reg) - rnd30(prod_reg));
            ST_WB:   flag_reg <= flag_reg | sat_ovf(sx32(p11_reg) - rnd30(prod_reg));
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (state_reg == ST_DONE && out_free)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            m_tdata_reg <= {bias_reg, rate_reg, ang_reg};
            m_tuser_reg <= {flag_reg && valid_axis_reg && (cmd_reg == CMD_UPDATE), axis_reg};
        end
    end

endmodule
